>>> hw/rtl/ptpd_pkg.sv
// ptpd_pkg: widths, reset values, register indexes and beat types for the
// pan/tilt pd tracker. No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ptpd_pkg;

	localparam int TGT_W     = 9;
	localparam int POS_W     = 10;
	localparam int GAIN_W    = 12;
	localparam int ERR_W     = TGT_W + 1;
	localparam int DIFF_W    = ERR_W + 1;
	// err*p needs ERR_W+GAIN_W, diff*d needs DIFF_W+GAIN_W, one more for the sum
	localparam int ACC_W     = DIFF_W + GAIN_W + 1;
	localparam int SUM_W     = ACC_W + 1;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = GAIN_W;

	localparam int CENTER_POS_DEF = 500;
	localparam int GAIN_SHIFT_DEF = 10;

	localparam logic [GAIN_W-1:0] PAN_P_RST  = GAIN_W'(400);
	localparam logic [GAIN_W-1:0] PAN_D_RST  = GAIN_W'(300);
	localparam logic [GAIN_W-1:0] TILT_P_RST = GAIN_W'(500);
	localparam logic [GAIN_W-1:0] TILT_D_RST = GAIN_W'(400);
	localparam logic [TGT_W-1:0]  X_CTR_RST  = TGT_W'(159);
	localparam logic [TGT_W-1:0]  Y_CTR_RST  = TGT_W'(99);
	localparam logic [POS_W-1:0]  POS_MIN_RST = POS_W'(0);
	localparam logic [POS_W-1:0]  POS_MAX_RST = POS_W'(1000);

	localparam logic [CFG_IDX_W-1:0] REG_PAN_P   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PAN_D   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TILT_P  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TILT_D  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_X_CTR   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_Y_CTR   = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_POS_MIN = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_POS_MAX = CFG_IDX_W'(7);

	typedef struct packed {
		logic [TGT_W-1:0] target_x;
		logic [TGT_W-1:0] target_y;
	} target_t;

	typedef struct packed {
		logic [POS_W-1:0] pan_pos;
		logic [POS_W-1:0] tilt_pos;
	} servo_t;

endpackage

>>> hw/rtl/pan_tilt_pd_tracker.sv
// Pan/tilt pd tracker: one target position in, one pair of servo positions out.
// Throughput is one beat per clock; a beat is registered in turn in the input
// register, the error/gain product stage and the position accumulate and
// clamp stage that feeds the output. The input only
// stalls while all three stages are full and the servo side is not ready.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps

module pan_tilt_pd_tracker #(
	parameter int CENTER_POS = ptpd_pkg::CENTER_POS_DEF,
	parameter int GAIN_SHIFT = ptpd_pkg::GAIN_SHIFT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ptpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ptpd_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic                                target_valid,
	output logic                                target_ready,
	input  ptpd_pkg::target_t                   target,
	output logic                                servo_valid,
	input  logic                                servo_ready,
	output ptpd_pkg::servo_t                    servo
);

	localparam int TGT_W  = ptpd_pkg::TGT_W;
	localparam int POS_W  = ptpd_pkg::POS_W;
	localparam int GAIN_W = ptpd_pkg::GAIN_W;
	localparam int ERR_W  = ptpd_pkg::ERR_W;
	localparam int DIFF_W = ptpd_pkg::DIFF_W;
	localparam int ACC_W  = ptpd_pkg::ACC_W;
	localparam int SUM_W  = ptpd_pkg::SUM_W;

	// configuration
	logic [GAIN_W-1:0] pan_p_q, pan_d_q, tilt_p_q, tilt_d_q;
	logic [TGT_W-1:0]  x_ctr_q, y_ctr_q;
	logic [POS_W-1:0]  pos_min_q, pos_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_p_q   <= ptpd_pkg::PAN_P_RST;
			pan_d_q   <= ptpd_pkg::PAN_D_RST;
			tilt_p_q  <= ptpd_pkg::TILT_P_RST;
			tilt_d_q  <= ptpd_pkg::TILT_D_RST;
			x_ctr_q   <= ptpd_pkg::X_CTR_RST;
			y_ctr_q   <= ptpd_pkg::Y_CTR_RST;
			pos_min_q <= ptpd_pkg::POS_MIN_RST;
			pos_max_q <= ptpd_pkg::POS_MAX_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ptpd_pkg::REG_PAN_P:   pan_p_q   <= cfg_data;
				ptpd_pkg::REG_PAN_D:   pan_d_q   <= cfg_data;
				ptpd_pkg::REG_TILT_P:  tilt_p_q  <= cfg_data;
				ptpd_pkg::REG_TILT_D:  tilt_d_q  <= cfg_data;
				ptpd_pkg::REG_X_CTR:   x_ctr_q   <= cfg_data[TGT_W-1:0];
				ptpd_pkg::REG_Y_CTR:   y_ctr_q   <= cfg_data[TGT_W-1:0];
				ptpd_pkg::REG_POS_MIN: pos_min_q <= cfg_data[POS_W-1:0];
				ptpd_pkg::REG_POS_MAX: pos_max_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, each stage fills when the one after it moves or is empty
	logic v_s1, v_s2, out_v_q;
	logic out_en, s2_en, s1_en;

	assign out_en       = !out_v_q || servo_ready;
	assign s2_en        = !v_s2 || out_en;
	assign s1_en        = !v_s1 || s2_en;
	assign target_ready = s1_en;

	// stage 1: input register
	ptpd_pkg::target_t tgt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_en) begin
			v_s1 <= target_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && target_valid) begin
			tgt_s1 <= target;
		end
	end

	// stage 2: errors and gain products
	logic signed [ERR_W-1:0]  pan_err, tilt_err;
	logic signed [ERR_W-1:0]  pan_last_q, tilt_last_q;
	logic signed [DIFF_W-1:0] pan_diff, tilt_diff;
	logic signed [ACC_W-1:0]  pan_acc, tilt_acc;
	logic signed [ACC_W-1:0]  pan_acc_s2, tilt_acc_s2;
	logic                     have_last_q, upd_s2;
	logic                     load_s2;

	assign load_s2 = s2_en && v_s1;

	always_comb begin
		pan_err   = $signed({1'b0, x_ctr_q}) - $signed({1'b0, tgt_s1.target_x});
		tilt_err  = $signed({1'b0, tgt_s1.target_y}) - $signed({1'b0, y_ctr_q});
		pan_diff  = $signed({pan_err[ERR_W-1], pan_err})
			- $signed({pan_last_q[ERR_W-1], pan_last_q});
		tilt_diff = $signed({tilt_err[ERR_W-1], tilt_err})
			- $signed({tilt_last_q[ERR_W-1], tilt_last_q});
		pan_acc   = $signed({{(ACC_W-ERR_W){pan_err[ERR_W-1]}}, pan_err})
				* $signed({{(ACC_W-GAIN_W){1'b0}}, pan_p_q})
			+ $signed({{(ACC_W-DIFF_W){pan_diff[DIFF_W-1]}}, pan_diff})
				* $signed({{(ACC_W-GAIN_W){1'b0}}, pan_d_q});
		tilt_acc  = $signed({{(ACC_W-ERR_W){tilt_err[ERR_W-1]}}, tilt_err})
				* $signed({{(ACC_W-GAIN_W){1'b0}}, tilt_p_q})
			+ $signed({{(ACC_W-DIFF_W){tilt_diff[DIFF_W-1]}}, tilt_diff})
				* $signed({{(ACC_W-GAIN_W){1'b0}}, tilt_d_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			have_last_q <= 1'b0;
			pan_last_q  <= '0;
			tilt_last_q <= '0;
		end else begin
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (load_s2) begin
				have_last_q <= 1'b1;
				pan_last_q  <= pan_err;
				tilt_last_q <= tilt_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			pan_acc_s2  <= pan_acc;
			tilt_acc_s2 <= tilt_acc;
			upd_s2      <= have_last_q;
		end
	end

	// stage 3: accumulate into position, clamp; position regs are the output payload
	logic signed [ACC_W-1:0] pan_step, tilt_step;
	logic signed [SUM_W-1:0] pan_sum, tilt_sum;
	logic signed [SUM_W-1:0] lo_ext, hi_ext;
	logic [POS_W-1:0]        pan_pos_q, tilt_pos_q;
	logic [POS_W-1:0]        pan_next, tilt_next;
	logic                    load_out;

	assign load_out = out_en && v_s2;

	always_comb begin
		pan_step  = pan_acc_s2 >>> GAIN_SHIFT;
		tilt_step = tilt_acc_s2 >>> GAIN_SHIFT;
		pan_sum   = $signed({{(SUM_W-POS_W){1'b0}}, pan_pos_q})
			+ $signed({pan_step[ACC_W-1], pan_step});
		tilt_sum  = $signed({{(SUM_W-POS_W){1'b0}}, tilt_pos_q})
			+ $signed({tilt_step[ACC_W-1], tilt_step});
		lo_ext    = $signed({{(SUM_W-POS_W){1'b0}}, pos_min_q});
		hi_ext    = $signed({{(SUM_W-POS_W){1'b0}}, pos_max_q});

		// max is checked first, so when min is above max a sum above max still gets max
		if (!upd_s2) begin
			pan_next = pan_pos_q;
		end else if (pan_sum > hi_ext) begin
			pan_next = pos_max_q;
		end else if (pan_sum < lo_ext) begin
			pan_next = pos_min_q;
		end else begin
			pan_next = pan_sum[POS_W-1:0];
		end

		if (!upd_s2) begin
			tilt_next = tilt_pos_q;
		end else if (tilt_sum > hi_ext) begin
			tilt_next = pos_max_q;
		end else if (tilt_sum < lo_ext) begin
			tilt_next = pos_min_q;
		end else begin
			tilt_next = tilt_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			pan_pos_q  <= POS_W'(CENTER_POS);
			tilt_pos_q <= POS_W'(CENTER_POS);
		end else begin
			if (out_en) begin
				out_v_q <= v_s2;
			end
			if (load_out) begin
				pan_pos_q  <= pan_next;
				tilt_pos_q <= tilt_next;
			end
		end
	end

	assign servo_valid    = out_v_q;
	assign servo.pan_pos  = pan_pos_q;
	assign servo.tilt_pos = tilt_pos_q;

endmodule

>>> hw/rtl/ptpd_checker.sv
// ptpd_checker: port-level checks for pan_tilt_pd_tracker, bound to the top level.
// Depends on ptpd_pkg.
`timescale 1ns / 1ps

module ptpd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              target_valid,
	input logic              target_ready,
	input ptpd_pkg::target_t target,
	input logic              servo_valid,
	input logic              servo_ready,
	input ptpd_pkg::servo_t  servo
);

	// beats taken but not yet delivered, at most three stages hold them
	logic [2:0] pend_q;
	logic       tgt_beat, srv_beat;

	assign tgt_beat = target_valid && target_ready;
	assign srv_beat = servo_valid && servo_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(tgt_beat) - 3'(srv_beat);
		end
	end

	a_servo_hold: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid && !servo_ready |=> servo_valid && $stable(servo))
		else $error("servo beat changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid |-> pend_q != 3'd0)
		else $error("servo beat without a pending target beat");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more beats in flight than pipeline stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!servo_valid |-> target_ready)
		else $error("input stalled while output is empty");

	a_servo_known: assert property (@(posedge clk) disable iff (!arst_n)
		servo_valid |-> !$isunknown(servo))
		else $error("servo beat carries unknown bits");

endmodule

bind pan_tilt_pd_tracker ptpd_checker u_ptpd_checker (.*);

>>> tb/tb_pan_tilt_pd_tracker.sv
// Self-checking bench for the pan/tilt pd tracker: drives target beats and
// register writes over valid/ready and checks every servo beat against a predictor.
// Depends on ptpd_pkg and pan_tilt_pd_tracker.
`timescale 1ns / 1ps

class tracker_scoreboard;
	int pan_p, pan_d, tilt_p, tilt_d;
	int x_ctr, y_ctr, pos_lo, pos_hi;
	int pan_at, tilt_at, pan_err_prev, tilt_err_prev;
	bit seen_first;
	ptpd_pkg::servo_t servo_due[$];
	int fail_count;

	function new();
		pan_p = ptpd_pkg::PAN_P_RST;
		pan_d = ptpd_pkg::PAN_D_RST;
		tilt_p = ptpd_pkg::TILT_P_RST;
		tilt_d = ptpd_pkg::TILT_D_RST;
		x_ctr = ptpd_pkg::X_CTR_RST;
		y_ctr = ptpd_pkg::Y_CTR_RST;
		pos_lo = ptpd_pkg::POS_MIN_RST;
		pos_hi = ptpd_pkg::POS_MAX_RST;
		pan_at = ptpd_pkg::CENTER_POS_DEF;
		tilt_at = ptpd_pkg::CENTER_POS_DEF;
		pan_err_prev = 0;
		tilt_err_prev = 0;
		seen_first = 1'b0;
		fail_count = 0;
	endfunction

	function void write_reg(logic [ptpd_pkg::CFG_IDX_W-1:0] idx,
		logic [ptpd_pkg::CFG_DAT_W-1:0] data);
		case (idx)
		ptpd_pkg::REG_PAN_P: pan_p = data;
		ptpd_pkg::REG_PAN_D: pan_d = data;
		ptpd_pkg::REG_TILT_P: tilt_p = data;
		ptpd_pkg::REG_TILT_D: tilt_d = data;
		ptpd_pkg::REG_X_CTR: x_ctr = data[ptpd_pkg::TGT_W-1:0];
		ptpd_pkg::REG_Y_CTR: y_ctr = data[ptpd_pkg::TGT_W-1:0];
		ptpd_pkg::REG_POS_MIN: pos_lo = data[ptpd_pkg::POS_W-1:0];
		ptpd_pkg::REG_POS_MAX: pos_hi = data[ptpd_pkg::POS_W-1:0];
		default: ;
		endcase
	endfunction

	// velocity-form step, floor shift, then max is tested before min
	function int move_axis(int at, int err, int prev, int p, int d);
		longint acc;
		longint moved;
		acc = longint'(err) * longint'(p) + longint'(err - prev) * longint'(d);
		moved = longint'(at) + (acc >>> ptpd_pkg::GAIN_SHIFT_DEF);
		if (moved > longint'(pos_hi))
			moved = pos_hi;
		else if (moved < longint'(pos_lo))
			moved = pos_lo;
		return int'(moved);
	endfunction

	function void take_target(ptpd_pkg::target_t t);
		int pan_err;
		int tilt_err;
		ptpd_pkg::servo_t s;
		pan_err = x_ctr - int'(t.target_x);
		tilt_err = int'(t.target_y) - y_ctr;
		if (seen_first) begin
			pan_at = move_axis(pan_at, pan_err, pan_err_prev, pan_p, pan_d);
			tilt_at = move_axis(tilt_at, tilt_err, tilt_err_prev, tilt_p, tilt_d);
		end
		pan_err_prev = pan_err;
		tilt_err_prev = tilt_err;
		seen_first = 1'b1;
		s.pan_pos = pan_at[ptpd_pkg::POS_W-1:0];
		s.tilt_pos = tilt_at[ptpd_pkg::POS_W-1:0];
		servo_due.push_back(s);
	endfunction

	function void check_servo(ptpd_pkg::servo_t got);
		ptpd_pkg::servo_t want;
		if (servo_due.size() == 0) begin
			$error("unexpected servo beat: pan_pos %0d tilt_pos %0d", got.pan_pos, got.tilt_pos);
			fail_count++;
			return;
		end
		want = servo_due.pop_front();
		if (got.pan_pos !== want.pan_pos) begin
			$error("pan_pos: expected %0d, actual %0d", want.pan_pos, got.pan_pos);
			fail_count++;
		end
		if (got.tilt_pos !== want.tilt_pos) begin
			$error("tilt_pos: expected %0d, actual %0d", want.tilt_pos, got.tilt_pos);
			fail_count++;
		end
	endfunction
endclass

module tb_pan_tilt_pd_tracker;

	localparam int TGT_W = ptpd_pkg::TGT_W;
	localparam int CFG_IDX_W = ptpd_pkg::CFG_IDX_W;
	localparam int CFG_DAT_W = ptpd_pkg::CFG_DAT_W;
	localparam int REG_COUNT = 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 125;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic target_valid = 1'b0;
	logic target_ready;
	ptpd_pkg::target_t target_beat = '0;
	logic servo_valid;
	logic servo_ready = 1'b0;
	ptpd_pkg::servo_t servo_beat;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	tracker_scoreboard sb = new();

	pan_tilt_pd_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.target_valid(target_valid),
		.target_ready(target_ready),
		.target(target_beat),
		.servo_valid(servo_valid),
		.servo_ready(servo_ready),
		.servo(servo_beat)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		servo_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// sampled before this edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (target_valid && target_ready)
				sb.take_target(target_beat);
			if (servo_valid && servo_ready)
				sb.check_servo(servo_beat);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task send_target(input int x, input int y);
		while ($urandom_range(99) < send_idle_pct) begin
			target_valid <= 1'b0;
			@(posedge clk);
		end
		target_beat <= '{target_x: TGT_W'(x), target_y: TGT_W'(y)};
		target_valid <= 1'b1;
		do @(posedge clk); while (!target_ready);
	endtask

	task drain_servo();
		target_valid <= 1'b0;
		do @(posedge clk); while (sb.servo_due.size() != 0);
	endtask

	// leaves cfg_valid high so back-to-back writes stream; end_cfg drops it
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task end_cfg();
		cfg_valid <= 1'b0;
	endtask

	function logic [CFG_DAT_W-1:0] pick_gain();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 7)
			return CFG_DAT_W'($urandom_range(600, 0));
		return CFG_DAT_W'($urandom);
	endfunction

	// upper data bits beyond the register width are random and must be dropped
	function logic [CFG_DAT_W-1:0] pick_center();
		int r;
		r = $urandom_range(5);
		if (r == 0)
			return {3'($urandom), 9'h000};
		if (r == 1)
			return {3'($urandom), 9'h1ff};
		return CFG_DAT_W'($urandom);
	endfunction

	task random_config();
		int lo;
		int hi;
		int r;
		write_reg(ptpd_pkg::REG_PAN_P, pick_gain());
		write_reg(ptpd_pkg::REG_PAN_D, pick_gain());
		write_reg(ptpd_pkg::REG_TILT_P, pick_gain());
		write_reg(ptpd_pkg::REG_TILT_D, pick_gain());
		write_reg(ptpd_pkg::REG_X_CTR, pick_center());
		write_reg(ptpd_pkg::REG_Y_CTR, pick_center());
		r = $urandom_range(9);
		if (r == 0) begin
			lo = 0;
			hi = 1023;
		end else if (r == 1) begin
			lo = $urandom_range(1023, 512);
			hi = $urandom_range(511, 0);
		end else begin
			lo = $urandom_range(450, 0);
			hi = $urandom_range(1023, 550);
		end
		write_reg(ptpd_pkg::REG_POS_MIN, {2'($urandom), 10'(lo)});
		write_reg(ptpd_pkg::REG_POS_MAX, {2'($urandom), 10'(hi)});
		if ($urandom_range(2) == 0)
			write_reg(CFG_IDX_W'($urandom_range(255, REG_COUNT)), CFG_DAT_W'($urandom));
		end_cfg();
	endtask

	// mostly small wander around the aim point so positions move without pinning
	task next_target();
		int x;
		int y;
		if ($urandom_range(9) < 3) begin
			x = $urandom_range(511, 0);
			y = $urandom_range(511, 0);
		end else begin
			x = sb.x_ctr + int'($urandom_range(60, 0)) - 30;
			y = sb.y_ctr + int'($urandom_range(60, 0)) - 30;
			if (x < 0) x = 0;
			if (x > 511) x = 511;
			if (y < 0) y = 0;
			if (y > 511) y = 511;
		end
		send_target(x, y);
	endtask

	task set_idle(input idle_mode_t mode);
		case (mode)
		IDLE_NONE: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		IDLE_SEND: begin
			send_idle_pct = 73;
			recv_stall_pct = 0;
		end
		IDLE_RECV: begin
			send_idle_pct = 0;
			recv_stall_pct = 73;
		end
		default: begin
			send_idle_pct = 7;
			recv_stall_pct = 7;
		end
		endcase
	endtask

	initial begin
		int hold_at;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first beat only records errors, then extremes drive into clamps
		send_target(159, 99);
		send_target(0, 0);
		send_target(511, 511);
		send_target(0, 511);
		send_target(511, 0);
		send_target(0, 0);
		send_target(0, 0);
		send_target(0, 0);
		drain_servo();

		// full and zero gains, masked centers, min above max, writes past the last register
		write_reg(ptpd_pkg::REG_PAN_P, '1);
		write_reg(ptpd_pkg::REG_PAN_D, '0);
		write_reg(ptpd_pkg::REG_TILT_P, '0);
		write_reg(ptpd_pkg::REG_TILT_D, '1);
		write_reg(ptpd_pkg::REG_X_CTR, 12'hfff);
		write_reg(ptpd_pkg::REG_Y_CTR, 12'he00);
		write_reg(ptpd_pkg::REG_POS_MIN, 12'(600));
		write_reg(ptpd_pkg::REG_POS_MAX, 12'(400));
		write_reg(CFG_IDX_W'(REG_COUNT), '0);
		write_reg('1, '0);
		end_cfg();
		send_target(0, 511);
		send_target(511, 0);
		send_target(256, 256);
		send_target(511, 511);
		send_target(0, 0);
		drain_servo();

		// unit gain so a one-pixel error shows the floor of a negative step
		write_reg(ptpd_pkg::REG_PAN_P, 12'(1));
		write_reg(ptpd_pkg::REG_PAN_D, '0);
		write_reg(ptpd_pkg::REG_TILT_P, 12'(1));
		write_reg(ptpd_pkg::REG_TILT_D, '0);
		write_reg(ptpd_pkg::REG_X_CTR, 12'(200));
		write_reg(ptpd_pkg::REG_Y_CTR, 12'(200));
		write_reg(ptpd_pkg::REG_POS_MIN, '0);
		write_reg(ptpd_pkg::REG_POS_MAX, 12'(1023));
		end_cfg();
		send_target(201, 199);
		send_target(199, 201);
		send_target(201, 201);
		send_target(200, 200);
		send_target(0, 511);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_servo();
			set_idle(idle_mode_t'(ph % 4));
			random_config();
			hold_at = $urandom_range(ITEMS_PER_PHASE - 10, 10);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n == hold_at)
					drain_servo();
				next_target();
			end
		end

		drain_servo();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
